// ----- src/mf3_pkg.sv -----
// Shared constants and types of the 3x3 median filter.
package mf3_pkg;

   localparam int WIDTH_BITS         = 11;
   localparam int HEIGHT_BITS        = 13;
   localparam int CSR_ADDR_BITS      = 2;
   localparam int CSR_DATA_BITS      = 13;
   localparam int FRAME_WIDTH_RESET  = 640;
   localparam int FRAME_HEIGHT_RESET = 480;
   localparam int OUT_DEPTH          = 8;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_FRAME_HEIGHT = 2'd1;

   typedef enum logic {
      REQ_PIXEL = 1'b0,
      REQ_DRAIN = 1'b1
   } req_kind_type;

   // sideband that travels with a result through the pipeline
   typedef struct packed {
      logic valid;
      logic copy;
      logic eor;
      logic eof;
   } meta_type;

endpackage

// ----- src/mf3_if.sv -----
// Channel interfaces of the 3x3 median filter: request, response, register write.
interface mf3_req_if #(parameter int PIXEL_BITS = 8);
   import mf3_pkg::*;
   logic                  valid;
   logic                  ready;
   req_kind_type          req_type;
   logic [PIXEL_BITS-1:0] pixel_in;
   modport source (output valid, req_type, pixel_in, input ready);
   modport sink   (input valid, req_type, pixel_in, output ready);
endinterface

interface mf3_rsp_if #(parameter int PIXEL_BITS = 8);
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] pixel_out;
   logic                  end_of_row;
   logic                  end_of_frame;
   modport source (output valid, pixel_out, end_of_row, end_of_frame, input ready);
   modport sink   (input valid, pixel_out, end_of_row, end_of_frame, output ready);
endinterface

interface mf3_csr_if;
   import mf3_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [CSR_ADDR_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/mf3_ram.sv -----
// Generic single-clock RAM, one write port, one registered read port.
module mf3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      rdata <= mem_ff[raddr];
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

endmodule

// ----- src/mf3_median.sv -----
// Median-of-nine network, stages two and three, with border-copy bypass.
module mf3_median #(
   parameter int PIXEL_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [PIXEL_BITS-1:0] window [9],
   input  mf3_pkg::meta_type     meta_in,
   input  logic [PIXEL_BITS-1:0] value_in,
   output logic [1:0]            busy,
   output mf3_pkg::meta_type     meta_out,
   output logic [PIXEL_BITS-1:0] pixel_out
);
   import mf3_pkg::*;

   function automatic logic [PIXEL_BITS-1:0] min2(input logic [PIXEL_BITS-1:0] a,
                                                  input logic [PIXEL_BITS-1:0] b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic [PIXEL_BITS-1:0] max2(input logic [PIXEL_BITS-1:0] a,
                                                  input logic [PIXEL_BITS-1:0] b);
      return (a > b) ? a : b;
   endfunction

   function automatic logic [PIXEL_BITS-1:0] med3(input logic [PIXEL_BITS-1:0] a,
                                                  input logic [PIXEL_BITS-1:0] b,
                                                  input logic [PIXEL_BITS-1:0] c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

   // stage two: each column sorted
   meta_type              m2_meta_ff, m2_meta_in;
   logic [PIXEL_BITS-1:0] m2_val_ff, m2_val_in;
   logic [PIXEL_BITS-1:0] lo_ff [3], lo_in [3];
   logic [PIXEL_BITS-1:0] md_ff [3], md_in [3];
   logic [PIXEL_BITS-1:0] hi_ff [3], hi_in [3];

   // stage three: max of lows, median of mids, min of highs
   meta_type              m3_meta_ff, m3_meta_in;
   logic [PIXEL_BITS-1:0] m3_val_ff, m3_val_in;
   logic [PIXEL_BITS-1:0] maxlo_ff, maxlo_in;
   logic [PIXEL_BITS-1:0] medmd_ff, medmd_in;
   logic [PIXEL_BITS-1:0] minhi_ff, minhi_in;

   always_comb begin
      m2_meta_in = meta_in;
      m2_val_in  = value_in;
      for (int c = 0; c < 3; c++) begin
         lo_in[c] = min2(min2(window[c], window[c+3]), window[c+6]);
         md_in[c] = med3(window[c], window[c+3], window[c+6]);
         hi_in[c] = max2(max2(window[c], window[c+3]), window[c+6]);
      end
      m3_meta_in = m2_meta_ff;
      m3_val_in  = m2_val_ff;
      maxlo_in   = max2(max2(lo_ff[0], lo_ff[1]), lo_ff[2]);
      medmd_in   = med3(md_ff[0], md_ff[1], md_ff[2]);
      minhi_in   = min2(min2(hi_ff[0], hi_ff[1]), hi_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_meta_ff <= '0;
         m3_meta_ff <= '0;
      end else begin
         m2_meta_ff <= m2_meta_in;
         m3_meta_ff <= m3_meta_in;
      end
      m2_val_ff <= m2_val_in;
      lo_ff     <= lo_in;
      md_ff     <= md_in;
      hi_ff     <= hi_in;
      m3_val_ff <= m3_val_in;
      maxlo_ff  <= maxlo_in;
      medmd_ff  <= medmd_in;
      minhi_ff  <= minhi_in;
   end

   assign busy      = {1'b0, m2_meta_ff.valid} + {1'b0, m3_meta_ff.valid};
   assign meta_out  = m3_meta_ff;
   assign pixel_out = m3_meta_ff.copy ? m3_val_ff : med3(maxlo_ff, medmd_ff, minhi_ff);

endmodule

// ----- src/mf3_out_fifo.sv -----
// Result queue that decouples the pipeline from response back-pressure.
module mf3_out_fifo #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic                       not_empty,
   output logic [WIDTH-1:0]           head,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   function automatic logic [AW-1:0] step(input logic [AW-1:0] p);
      return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? step(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? step(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign not_empty = count_ff != '0;
   assign head      = mem_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

// ----- src/median_filter_3x3_core.sv -----
// Top level of the 3x3 median filter over a raster pixel stream.
//
//   channel   dir   beat carries                              handshake
//   req_bus   in    req_type, pixel_in                        valid/ready
//   rsp_bus   out   pixel_out, end_of_row, end_of_frame       valid/ready
//   csr_bus   in    index, data (frame_width, frame_height)   valid/ready, ready always high
//
// One request beat per clock while request ready is high. A result passes through
// the line store read, window update, two median network stages, then the result queue.
// Request ready drops while the queue plus beats in flight reach OUT_DEPTH.
// Synchronous reset clears counters, window and pipeline; the line stores are not cleared.
// A frame_width or frame_height write restarts the frame; any write is taken in any cycle.
module median_filter_3x3_core #(
   parameter int MAX_WIDTH  = 1024,
   parameter int PIXEL_BITS = 8
) (
   input logic         clock,
   input logic         reset,
   mf3_req_if.sink     req_bus,
   mf3_rsp_if.source   rsp_bus,
   mf3_csr_if.sink     csr_bus
);
   import mf3_pkg::*;

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int PW  = $clog2(MAX_WIDTH + 2);
   localparam int FW  = PIXEL_BITS + 2;
   localparam int QCW = $clog2(OUT_DEPTH + 1);

   function automatic logic [CW-1:0] width_m1(input logic [WIDTH_BITS-1:0] raw);
      logic [CW-1:0] res;
      if (raw == '0) begin
         res = '0;
      end else if (int'(raw) > MAX_WIDTH) begin
         res = CW'(MAX_WIDTH - 1);
      end else begin
         res = CW'(raw - WIDTH_BITS'(1));
      end
      return res;
   endfunction

   function automatic logic [HEIGHT_BITS-1:0] height_m1(input logic [HEIGHT_BITS-1:0] raw);
      return (raw == '0) ? '0 : raw - HEIGHT_BITS'(1);
   endfunction

   // frame geometry and position
   logic [CW-1:0]          wm1_ff, wm1_in;
   logic [HEIGHT_BITS-1:0] hm1_ff, hm1_in;
   logic [CW-1:0]          col_ff, col_in;
   logic [HEIGHT_BITS-1:0] row_ff, row_in;
   logic [PW-1:0]          pending_ff, pending_in;

   // line store read stage
   logic                   s1_pix_ff, s1_pix_in;
   logic                   s1_drain_ff, s1_drain_in;
   logic                   s1_upper_ff, s1_upper_in;
   meta_type               s1_meta_ff, s1_meta_in;
   logic [CW-1:0]          s1_addr_ff, s1_addr_in;
   logic [PIXEL_BITS-1:0]  s1_px_ff, s1_px_in;

   // last line store write, for same-address forwarding
   logic                   wr_valid_ff, wr_valid_in;
   logic [CW-1:0]          wr_addr_ff, wr_addr_in;
   logic [PIXEL_BITS-1:0]  wr_up_ff, wr_up_in;
   logic [PIXEL_BITS-1:0]  wr_mid_ff, wr_mid_in;

   logic [PIXEL_BITS-1:0]  window_ff [9];
   logic [PIXEL_BITS-1:0]  window_in [9];
   meta_type               m1_meta_ff, m1_meta_in;
   logic [PIXEL_BITS-1:0]  m1_val_ff, m1_val_in;

   logic [CW-1:0]          rd_addr;
   logic [PIXEL_BITS-1:0]  up_q, mid_q, up_eff, mid_eff;
   logic                   fwd;

   logic                   take, pix_take, drn_take, cfg_take, restart;
   logic                   col_nz, emit, border, d_upper;
   logic [CW-1:0]          co, d_col;
   logic [HEIGHT_BITS-1:0] ro;
   logic [PW-1:0]          w_p;

   logic [1:0]             med_busy;
   meta_type               med_meta;
   logic [PIXEL_BITS-1:0]  med_pixel;
   logic [FW-1:0]          q_head;
   logic [QCW-1:0]         q_count;
   logic                   q_not_empty;
   logic [QCW:0]           load;

   assign csr_bus.ready = 1'b1;
   assign cfg_take      = csr_bus.valid;

   assign load = {1'b0, q_count} + (QCW+1)'(s1_meta_ff.valid) + (QCW+1)'(m1_meta_ff.valid)
               + (QCW+1)'(med_busy);
   assign req_bus.ready = load < (QCW+1)'(OUT_DEPTH);

   assign take     = req_bus.valid && req_bus.ready;
   assign pix_take = take && (req_bus.req_type == REQ_PIXEL) && (pending_ff == '0);
   assign drn_take = take && (req_bus.req_type == REQ_DRAIN) && (pending_ff != '0);

   // request side: position, drain source and line store address
   always_comb begin
      w_p     = PW'(wm1_ff) + PW'(1);
      col_nz  = col_ff != '0;
      co      = col_nz ? col_ff - CW'(1) : wm1_ff;
      ro      = col_nz ? row_ff - HEIGHT_BITS'(1) : row_ff - HEIGHT_BITS'(2);
      emit    = (row_ff >= HEIGHT_BITS'(2)) || ((row_ff == HEIGHT_BITS'(1)) && col_nz);
      border  = (ro == '0) || (ro == hm1_ff) || (co == '0) || (co == wm1_ff);
      d_upper = pending_ff > w_p;
      d_col   = CW'(w_p - pending_ff);
      rd_addr = (req_bus.req_type == REQ_DRAIN) ? (d_upper ? wm1_ff : d_col) : col_ff;

      wm1_in     = wm1_ff;
      hm1_in     = hm1_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      pending_in = pending_ff;
      restart    = 1'b0;

      if (cfg_take) begin
         case (csr_bus.index)
            CSR_FRAME_WIDTH: begin
               wm1_in  = width_m1(csr_bus.data[WIDTH_BITS-1:0]);
               restart = 1'b1;
            end
            CSR_FRAME_HEIGHT: begin
               hm1_in  = height_m1(csr_bus.data[HEIGHT_BITS-1:0]);
               restart = 1'b1;
            end
            default: begin
            end
         endcase
      end

      if (restart) begin
         col_in     = '0;
         row_in     = '0;
         pending_in = '0;
      end else if (pix_take) begin
         if (col_ff == wm1_ff) begin
            col_in = '0;
            if (row_ff == hm1_ff) begin
               row_in     = '0;
               pending_in = (hm1_ff == '0) ? w_p : w_p + PW'(1);
            end else begin
               row_in = row_ff + HEIGHT_BITS'(1);
            end
         end else begin
            col_in = col_ff + CW'(1);
         end
      end else if (drn_take) begin
         pending_in = pending_ff - PW'(1);
      end

      s1_pix_in   = pix_take;
      s1_drain_in = drn_take;
      s1_upper_in = d_upper;
      s1_addr_in  = rd_addr;
      s1_px_in    = req_bus.pixel_in;
      s1_meta_in.valid = (pix_take && emit) || drn_take;
      s1_meta_in.copy  = drn_take || border;
      s1_meta_in.eor   = drn_take ? (d_upper || (pending_ff == PW'(1))) : (co == wm1_ff);
      s1_meta_in.eof   = drn_take && !d_upper && (pending_ff == PW'(1));
   end

   // read stage: forward the previous cycle's write, shift the window, write back
   always_comb begin
      fwd     = wr_valid_ff && (wr_addr_ff == s1_addr_ff);
      up_eff  = fwd ? wr_up_ff : up_q;
      mid_eff = fwd ? wr_mid_ff : mid_q;

      wr_valid_in = s1_pix_ff;
      wr_addr_in  = s1_addr_ff;
      wr_up_in    = mid_eff;
      wr_mid_in   = s1_px_ff;

      window_in = window_ff;
      if (s1_pix_ff) begin
         window_in[0] = window_ff[1];
         window_in[1] = window_ff[2];
         window_in[2] = up_eff;
         window_in[3] = window_ff[4];
         window_in[4] = window_ff[5];
         window_in[5] = mid_eff;
         window_in[6] = window_ff[7];
         window_in[7] = window_ff[8];
         window_in[8] = s1_px_ff;
      end

      m1_meta_in = s1_meta_ff;
      m1_val_in  = s1_drain_ff ? (s1_upper_ff ? up_eff : mid_eff) : window_ff[5];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wm1_ff      <= width_m1(WIDTH_BITS'(FRAME_WIDTH_RESET));
         hm1_ff      <= height_m1(HEIGHT_BITS'(FRAME_HEIGHT_RESET));
         col_ff      <= '0;
         row_ff      <= '0;
         pending_ff  <= '0;
         s1_pix_ff   <= 1'b0;
         s1_drain_ff <= 1'b0;
         s1_meta_ff  <= '0;
         wr_valid_ff <= 1'b0;
         m1_meta_ff  <= '0;
         for (int i = 0; i < 9; i++) begin
            window_ff[i] <= '0;
         end
      end else begin
         wm1_ff      <= wm1_in;
         hm1_ff      <= hm1_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         pending_ff  <= pending_in;
         s1_pix_ff   <= s1_pix_in;
         s1_drain_ff <= s1_drain_in;
         s1_meta_ff  <= s1_meta_in;
         wr_valid_ff <= wr_valid_in;
         m1_meta_ff  <= m1_meta_in;
         window_ff   <= window_in;
      end
      s1_upper_ff <= s1_upper_in;
      s1_addr_ff  <= s1_addr_in;
      s1_px_ff    <= s1_px_in;
      wr_addr_ff  <= wr_addr_in;
      wr_up_ff    <= wr_up_in;
      wr_mid_ff   <= wr_mid_in;
      m1_val_ff   <= m1_val_in;
   end

   mf3_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_upper_line (
      .clock (clock),
      .we    (s1_pix_ff),
      .waddr (s1_addr_ff),
      .wdata (mid_eff),
      .raddr (rd_addr),
      .rdata (up_q)
   );

   mf3_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_middle_line (
      .clock (clock),
      .we    (s1_pix_ff),
      .waddr (s1_addr_ff),
      .wdata (s1_px_ff),
      .raddr (rd_addr),
      .rdata (mid_q)
   );

   mf3_median #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_median (
      .clock     (clock),
      .reset     (reset),
      .window    (window_ff),
      .meta_in   (m1_meta_ff),
      .value_in  (m1_val_ff),
      .busy      (med_busy),
      .meta_out  (med_meta),
      .pixel_out (med_pixel)
   );

   mf3_out_fifo #(
      .WIDTH (FW),
      .DEPTH (OUT_DEPTH)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (med_meta.valid),
      .push_data ({med_meta.eor, med_meta.eof, med_pixel}),
      .pop       (rsp_bus.valid && rsp_bus.ready),
      .not_empty (q_not_empty),
      .head      (q_head),
      .count     (q_count)
   );

   assign rsp_bus.valid        = q_not_empty;
   assign rsp_bus.pixel_out    = q_head[PIXEL_BITS-1:0];
   assign rsp_bus.end_of_row   = q_head[FW-1];
   assign rsp_bus.end_of_frame = q_head[FW-2];

endmodule

// ----- test/mf3_result_check.sv -----
`timescale 1ns / 1ps
// Result checker of the 3x3 median filter: tracks frames, predicts filtered pixels, compares.
module mf3_result_check #(
   parameter int MAX_WIDTH  = 1024,
   parameter int PIXEL_BITS = 8
) (
   input  logic clock,
   input  logic reset,
   mf3_req_if   req_mon,
   mf3_rsp_if   rsp_mon,
   mf3_csr_if   csr_mon,
   output int   fail_count,
   output int   results_owed
);
   import mf3_pkg::*;

   typedef logic [PIXEL_BITS-1:0] pixel_type;

   typedef struct packed {
      pixel_type pixel;
      logic      eor;
      logic      eof;
   } out_pixel_type;

   out_pixel_type expected_pixels [$];

   logic [WIDTH_BITS-1:0]  width_reg;
   logic [HEIGHT_BITS-1:0] height_reg;
   pixel_type              upper_row  [MAX_WIDTH];
   pixel_type              middle_row [MAX_WIDTH];
   pixel_type              win [9];
   int                     col_pos;
   int                     row_pos;
   int                     owed_drain;

   function automatic int active_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return int'(width_reg);
   endfunction

   function automatic int active_height();
      return (height_reg == 0) ? 1 : int'(height_reg);
   endfunction

   // partial selection sort: after five passes slot 4 holds the fifth smallest
   function automatic pixel_type window_median();
      pixel_type s [9];
      pixel_type t;
      for (int i = 0; i < 9; i++) s[i] = win[i];
      for (int i = 0; i < 5; i++) begin
         for (int j = i + 1; j < 9; j++) begin
            if (s[j] < s[i]) begin
               t    = s[i];
               s[i] = s[j];
               s[j] = t;
            end
         end
      end
      return s[4];
   endfunction

   function automatic void restart_frame();
      col_pos    = 0;
      row_pos    = 0;
      owed_drain = 0;
   endfunction

   function automatic void queue_result(input out_pixel_type res);
      expected_pixels.insert(expected_pixels.size(), res);
   endfunction

   function automatic void take_pixel(input pixel_type px);
      int            w, h, col, row, co, ro;
      pixel_type     up, mid;
      out_pixel_type res;
      w = active_width();
      h = active_height();
      // pixels arriving while the frame tail is owed are dropped
      if (owed_drain != 0) return;
      col = col_pos;
      row = row_pos;
      if (col >= w) col = w - 1;
      up  = upper_row[col];
      mid = middle_row[col];
      upper_row[col]  = mid;
      middle_row[col] = px;
      for (int r = 0; r < 3; r++) begin
         win[3*r]   = win[3*r+1];
         win[3*r+1] = win[3*r+2];
      end
      win[2] = up;
      win[5] = mid;
      win[8] = px;
      if (row * w + col >= w + 1) begin
         if (col >= 1) begin
            co = col - 1;
            ro = row - 1;
         end else begin
            co = w - 1;
            ro = row - 2;
         end
         if (ro == 0 || ro == h - 1 || co == 0 || co == w - 1) res.pixel = win[4];
         else res.pixel = window_median();
         res.eor = (co == w - 1);
         res.eof = 1'b0;
         queue_result(res);
      end
      col++;
      if (col >= w) begin
         col = 0;
         row++;
         if (row >= h) begin
            row        = 0;
            owed_drain = (h == 1) ? w : w + 1;
         end
      end
      col_pos = col;
      row_pos = row;
   endfunction

   function automatic void take_drain();
      int            w, c;
      out_pixel_type res;
      w = active_width();
      if (owed_drain == 0) return;
      if (owed_drain > w) begin
         // last pixel of the row above the bottom row
         res.pixel = upper_row[w-1];
         res.eor   = 1'b1;
         res.eof   = 1'b0;
      end else begin
         c         = w - owed_drain;
         res.pixel = middle_row[c];
         res.eor   = (c == w - 1);
         res.eof   = (owed_drain == 1);
      end
      queue_result(res);
      owed_drain--;
   endfunction

   task automatic flag_error(input string what);
      fail_count++;
      if (fail_count <= 10) $display("%0t: %s", $time, what);
   endtask

   task automatic check_result();
      out_pixel_type want;
      if (expected_pixels.size() == 0) begin
         flag_error($sformatf("unexpected beat: pixel=%0d eor=%0b eof=%0b",
                              rsp_mon.pixel_out, rsp_mon.end_of_row, rsp_mon.end_of_frame));
         return;
      end
      want = expected_pixels.pop_front();
      if (rsp_mon.pixel_out !== want.pixel || rsp_mon.end_of_row !== want.eor
          || rsp_mon.end_of_frame !== want.eof)
         flag_error($sformatf({"wrong beat: expected pixel=%0d eor=%0b eof=%0b,",
                               " got pixel=%0d eor=%0b eof=%0b"},
                              want.pixel, want.eor, want.eof, rsp_mon.pixel_out,
                              rsp_mon.end_of_row, rsp_mon.end_of_frame));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_pixels.delete();
         width_reg  = WIDTH_BITS'(FRAME_WIDTH_RESET);
         height_reg = HEIGHT_BITS'(FRAME_HEIGHT_RESET);
         for (int i = 0; i < MAX_WIDTH; i++) begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
         end
         for (int i = 0; i < 9; i++) win[i] = '0;
         restart_frame();
         fail_count = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) check_result();
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_FRAME_WIDTH: begin
                  width_reg = csr_mon.data[WIDTH_BITS-1:0];
                  restart_frame();
               end
               CSR_FRAME_HEIGHT: begin
                  height_reg = csr_mon.data[HEIGHT_BITS-1:0];
                  restart_frame();
               end
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.req_type == REQ_DRAIN) take_drain();
            else take_pixel(req_mon.pixel_in);
         end
      end
      results_owed <= expected_pixels.size();
   end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// Testbench top of the 3x3 median filter: clock, reset, frame stimulus and verdict.
module tb;
   import mf3_pkg::*;

   localparam int    MAX_WIDTH     = 1024;
   localparam int    PIXEL_BITS    = 8;
   localparam int    HALF_PERIOD   = 5;
   localparam int    SETTLE_CYCLES = 12;
   localparam int    RANDOM_ITEMS  = 400;
   localparam longint TIMEOUT_NS   = 20_000_000;

   // indexes with no register behind them
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SPARE_3 = 2'd3;

   typedef logic [PIXEL_BITS-1:0]    pixel_type;
   typedef logic [CSR_DATA_BITS-1:0] csr_word_type;
   typedef enum {MIX_UNIFORM, MIX_RAILS, MIX_NARROW} pixel_mix_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   bit        src_idles  = 1'b1;
   bit        sink_idles = 1'b1;
   int        fail_count;
   int        results_owed;
   int        frame_w;
   int        frame_h;
   int        live_beats;
   pixel_type narrow_base;

   mf3_req_if #(.PIXEL_BITS(PIXEL_BITS)) req_bus ();
   mf3_rsp_if #(.PIXEL_BITS(PIXEL_BITS)) rsp_bus ();
   mf3_csr_if                            csr_bus ();

   median_filter_3x3_core #(
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (PIXEL_BITS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   mf3_result_check #(
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (PIXEL_BITS)
   ) result_check (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_bus),
      .rsp_mon      (rsp_bus),
      .csr_mon      (csr_bus),
      .fail_count   (fail_count),
      .results_owed (results_owed)
   );

   always #(HALF_PERIOD) clock = ~clock;

   initial begin
      #(TIMEOUT_NS);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // result side: random stall before each beat while sink_idles is set
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         stall = sink_idles ? $urandom_range(0, 15) : 0;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   function automatic pixel_type draw_pixel(input pixel_mix_type mix);
      case (mix)
         MIX_RAILS:  return $urandom_range(0, 1) ? pixel_type'($urandom_range(0, 1))
                                                 : ~pixel_type'($urandom_range(0, 1));
         MIX_NARROW: return narrow_base + pixel_type'($urandom_range(0, 3));
         default:    return pixel_type'($urandom);
      endcase
   endfunction

   // entered and left at a falling edge
   task automatic send_beat(input req_kind_type kind, input pixel_type px);
      int gap;
      gap = src_idles ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= kind;
      req_bus.pixel_in <= px;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic wait_for_quiet();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (results_owed != 0);
   endtask

   // only once the pipeline has emptied
   task automatic write_reg(input logic [CSR_ADDR_BITS-1:0] idx, input csr_word_type val);
      wait_for_quiet();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic set_frame(input csr_word_type wdata, input csr_word_type hdata);
      logic [WIDTH_BITS-1:0] wf;
      if ($urandom_range(0, 1)) begin
         write_reg(CSR_FRAME_WIDTH, wdata);
         write_reg(CSR_FRAME_HEIGHT, hdata);
      end else begin
         write_reg(CSR_FRAME_HEIGHT, hdata);
         write_reg(CSR_FRAME_WIDTH, wdata);
      end
      if ($urandom_range(0, 7) == 0)
         write_reg($urandom_range(0, 1) ? CSR_SPARE_2 : CSR_SPARE_3, csr_word_type'($urandom));
      wf      = wdata[WIDTH_BITS-1:0];
      frame_w = (wf == 0) ? 1 : (wf > MAX_WIDTH) ? MAX_WIDTH : int'(wf);
      frame_h = (hdata[HEIGHT_BITS-1:0] == 0) ? 1 : int'(hdata[HEIGHT_BITS-1:0]);
   endtask

   // one frame plus its drain ticks; may stop early so the next write restarts it
   task automatic send_frame(input pixel_mix_type mix, input bit may_abort, output bit cut);
      int pixels, total, stop_at, stray_at;
      pixels   = frame_w * frame_h;
      total    = pixels + ((frame_h == 1) ? frame_w : frame_w + 1);
      stop_at  = (may_abort && $urandom_range(0, 15) == 0) ? $urandom_range(1, total - 1)
                                                           : total;
      stray_at = ($urandom_range(0, 5) == 0) ? $urandom_range(pixels, total - 1) : -1;
      cut      = (stop_at < total);
      for (int n = 0; n < stop_at; n++) begin
         if (n == stray_at) send_beat(REQ_PIXEL, draw_pixel(mix));
         if ($urandom_range(0, 199) == 0) wait_for_quiet();
         if (n < pixels) send_beat(REQ_PIXEL, draw_pixel(mix));
         else send_beat(REQ_DRAIN, pixel_type'($urandom));
         live_beats++;
      end
      // a tick with nothing owed
      if (!cut && $urandom_range(0, 5) == 0) send_beat(REQ_DRAIN, pixel_type'($urandom));
   endtask

   task automatic run_phase(input csr_word_type wdata, input csr_word_type hdata,
                            input int frames, input bit may_abort);
      bit cut;
      set_frame(wdata, hdata);
      for (int f = 0; f < frames; f++) begin
         narrow_base = pixel_type'($urandom);
         send_frame(pixel_mix_type'($urandom_range(0, 2)), may_abort, cut);
         if (cut) break;
      end
   endtask

   initial begin
      int wsel, hsel;
      req_bus.valid    = 1'b0;
      req_bus.req_type = REQ_PIXEL;
      req_bus.pixel_in = '0;
      csr_bus.valid    = 1'b0;
      csr_bus.index    = CSR_FRAME_WIDTH;
      csr_bus.data     = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // directed: spare indexes, a 3x3 frame with rail values, odd ticks and pixels
      write_reg(CSR_SPARE_2, 13'h1555);
      write_reg(CSR_SPARE_3, 13'h0AAA);
      set_frame(13'd3, 13'd3);
      send_beat(REQ_DRAIN, 8'h5A);
      send_beat(REQ_PIXEL, 8'd0);   send_beat(REQ_PIXEL, 8'd255); send_beat(REQ_PIXEL, 8'd7);
      send_beat(REQ_PIXEL, 8'd255); send_beat(REQ_PIXEL, 8'd0);   send_beat(REQ_PIXEL, 8'd200);
      send_beat(REQ_PIXEL, 8'd13);  send_beat(REQ_PIXEL, 8'd255); send_beat(REQ_PIXEL, 8'd0);
      wait_for_quiet();
      send_beat(REQ_PIXEL, 8'hFF);
      repeat (4) send_beat(REQ_DRAIN, 8'h00);
      send_beat(REQ_DRAIN, 8'hA5);

      // size extremes, including out-of-range widths and zero height
      run_phase(13'h0000, 13'd5, 2, 1'b0);
      src_idles  = 1'b0;
      sink_idles = 1'b0;
      // oversized width acts as the line store size: one full row, then the first ticks
      set_frame(13'h1FFF, 13'd1);
      repeat (frame_w) send_beat(REQ_PIXEL, draw_pixel(MIX_UNIFORM));
      repeat (3) send_beat(REQ_DRAIN, pixel_type'($urandom));
      // tallest frame, cut short by the next register write
      set_frame(13'd1, 13'h1FFF);
      narrow_base = pixel_type'($urandom);
      repeat (12) send_beat(REQ_PIXEL, draw_pixel(MIX_NARROW));
      src_idles  = 1'b1;
      sink_idles = 1'b1;
      run_phase(13'd2, 13'd0, 2, 1'b0);
      run_phase(13'h1804, 13'd2, 2, 1'b0);

      live_beats = 0;
      while (live_beats < RANDOM_ITEMS) begin
         src_idles  = ($urandom_range(0, 3) != 0);
         sink_idles = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 9))
            0:       wsel = $urandom_range(1, 2);
            1, 2:    wsel = $urandom_range(11, 32);
            default: wsel = $urandom_range(3, 10);
         endcase
         case ($urandom_range(0, 9))
            0, 1:    hsel = $urandom_range(0, 2);
            2:       hsel = $urandom_range(8, 16);
            default: hsel = $urandom_range(3, 7);
         endcase
         run_phase(csr_word_type'(wsel), csr_word_type'(hsel), $urandom_range(1, 3), 1'b1);
      end

      wait_for_quiet();
      repeat (2 * SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ----- files.f -----
src/mf3_pkg.sv
src/mf3_if.sv
src/mf3_ram.sv
src/mf3_median.sv
src/mf3_out_fifo.sv
src/median_filter_3x3_core.sv
test/mf3_result_check.sv
test/tb.sv
